FILE: sv/pic8_pkg.sv
`default_nettype none

package pic8_pkg;

    localparam int unsigned NUM_LINES  = 8;
    localparam int unsigned LINE_W     = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned VECTOR_W   = 11;
    localparam int unsigned LEVEL_LINE = 3;

    localparam logic [BYTE_W-1:0] ADDR_VECTOR = 8'hB0;
    localparam logic [BYTE_W-1:0] ADDR_ENABLE = 8'hB2;
    localparam logic [BYTE_W-1:0] ADDR_ACK    = 8'hB6;

    typedef enum logic [1:0] {
        MODE_LEVEL = 2'd0,
        MODE_PULSE = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] write_data;
        logic [BYTE_W-1:0] address;
        logic              level;
        logic [LINE_W-1:0] line;
        mode_t             mode;
    } item_t;

    typedef struct packed {
        logic [VECTOR_W-1:0] irq_vector;
        logic [LINE_W-1:0]   irq_line;
        logic                irq_pending;
        logic [BYTE_W-1:0]   read_data;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/pic8_core.sv
`default_nettype none

module pic8_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire pic8_pkg::item_t   item,
    output pic8_pkg::result_t      result
);
    import pic8_pkg::*;

    logic [NUM_LINES-1:0] line_levels_reg, line_levels_next;
    logic [NUM_LINES-1:0] pending_reg, pending_next;
    logic [NUM_LINES-1:0] enable_reg, enable_next;
    logic [BYTE_W-1:0]    base_reg, base_next;

    logic [NUM_LINES-1:0] line_bit;
    logic [NUM_LINES-1:0] pend_event;
    logic [NUM_LINES-1:0] live;
    logic                 win_valid;
    logic [LINE_W-1:0]    win_line;
    logic [NUM_LINES-1:0] lvl_bit;

    assign line_bit = NUM_LINES'(1) << item.line;
    assign lvl_bit  = NUM_LINES'(1) << LEVEL_LINE;

    // State update for one beat, including the re-latch of the level line.
    always_comb begin
        line_levels_next = line_levels_reg;
        pending_next     = pending_reg;
        enable_next      = enable_reg;
        base_next        = base_reg;
        unique case (item.mode)
            MODE_LEVEL: begin
                line_levels_next = item.level ? (line_levels_reg | line_bit)
                                              : (line_levels_reg & ~line_bit);
                pending_next = pending_reg | ((line_levels_reg ^ line_levels_next)
                                              & line_levels_next & enable_reg);
            end
            MODE_PULSE: begin
                pending_next = pending_reg | (line_bit & enable_reg);
            end
            MODE_WRITE: begin
                priority if (item.address == ADDR_VECTOR) begin
                    base_next = item.write_data;
                end else if (item.address == ADDR_ENABLE) begin
                    enable_next  = item.write_data;
                    pending_next = pending_reg & item.write_data;
                end else if (item.address == ADDR_ACK) begin
                    pending_next = pending_reg & ~item.write_data;
                end else begin
                    pending_next = pending_reg;
                end
            end
            MODE_READ: begin
                pending_next = pending_reg;
            end
            default: begin
                pending_next = pending_reg;
            end
        endcase
        pend_event   = line_levels_next & lvl_bit & enable_next;
        pending_next = pending_next | pend_event;
    end

    assign live = pending_next & enable_next;

    always_comb begin
        win_valid = 1'b0;
        win_line  = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--) begin
            if (live[i]) begin
                win_valid = 1'b1;
                win_line  = LINE_W'(i);
            end
        end
    end

    always_comb begin
        result.read_data = '0;
        if (item.mode == MODE_READ) begin
            priority if (item.address == ADDR_VECTOR) begin
                result.read_data = base_next;
            end else if (item.address == ADDR_ENABLE) begin
                result.read_data = enable_next;
            end else if (item.address == ADDR_ACK) begin
                result.read_data = NUM_LINES'(1) << win_line;
            end else begin
                result.read_data = '0;
            end
        end
        result.irq_pending = win_valid;
        result.irq_line    = win_valid ? win_line : '0;
        result.irq_vector  = win_valid
            ? VECTOR_W'({({1'b0, base_next} + {6'd0, win_line}), 2'b00})
            : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_levels_reg <= '0;
            pending_reg     <= '0;
            enable_reg      <= '0;
            base_reg        <= '0;
        end else if (accept) begin
            line_levels_reg <= line_levels_next;
            pending_reg     <= pending_next;
            enable_reg      <= enable_next;
            base_reg        <= base_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pic8_out_buf.sv
`default_nettype none

module pic8_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pic8_pkg::result_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pic8_pkg::result_t      out_data
);
    import pic8_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    // The skid stage holds one beat that arrived while the output was stalled.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (in_valid && in_ready) begin
            if (!out_valid_reg || out_ready) begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (out_valid_reg && out_ready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

FILE: sv/priority_interrupt_controller_8_line.sv
// Eight-line priority interrupt controller with a register bus folded into
// one input stream.
// Input channel (s_): each beat is one event. s_tuser gives its kind: line
// level change, one-shot pulse, bus write or bus read. s_tdata carries the
// line number, the new level, the bus address and the write byte.
// Result channel (m_): exactly one beat per input beat, in order. It carries
// the bus read byte (zero unless a read hits vector base, enable or
// acknowledge) and the interrupt state after the event: pending flag, winning
// line and its vector (base + line) * 4.
// The result is registered in the output buffer, and one beat can be taken every
// cycle while the skid stage is empty; the state update and priority encode sit
// between the input handshake and the output register.
// Reset clears line levels, pending bits, enables and vector base, and
// empties the output register and skid stage.
// When m_tready is low the result is held; one further input beat is taken
// into the skid stage, after which s_tready drops until the output drains.
`default_nettype none

module priority_interrupt_controller_8_line (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] line, [3] level, [11:4] address, [19:12] write_data, [23:20] zero
    input  wire logic [23:0] s_tdata,
    // [1:0] mode
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] read_data, [8] irq_pending, [11:9] irq_line, [22:12] irq_vector,
    // [23] zero
    output logic [23:0]      m_tdata
);
    import pic8_pkg::*;

    item_t   item;
    result_t core_result;
    result_t out_result;
    logic    accept;

    assign item.mode       = mode_t'(s_tuser);
    assign item.line       = s_tdata[2:0];
    assign item.level      = s_tdata[3];
    assign item.address    = s_tdata[11:4];
    assign item.write_data = s_tdata[19:12];

    assign accept = s_tvalid && s_tready;

    pic8_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (item),
        .result  (core_result)
    );

    pic8_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {1'b0, out_result};

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pic8_pkg::*;

    localparam int RAND_EVENTS = 1500;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        item_t   ev;
        logic    typed;
        result_t want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Shadow copy of the controller state.
    logic [7:0] lvl_shadow;
    logic [7:0] pend_shadow;
    logic [7:0] enable_shadow;
    logic [7:0] base_shadow;

    result_t  irq_expected[$];
    dir_row_t dir_rows[$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       calm = 1'b0;

    priority_interrupt_controller_8_line uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Applies one event to the shadow state and returns the interrupt state after it.
    function automatic result_t apply_irq_event(item_t ev);
        logic [7:0] prev;
        logic [7:0] sel;
        logic [7:0] live;
        logic [2:0] win;
        logic       found;
        logic [7:0] rd;
        result_t    r;
        int         i;
        sel = 8'd1 << ev.line;
        rd = 8'd0;
        case (ev.mode)
            MODE_LEVEL: begin
                prev = lvl_shadow;
                lvl_shadow = ev.level ? (lvl_shadow | sel) : (lvl_shadow & ~sel);
                pend_shadow |= (prev ^ lvl_shadow) & lvl_shadow & enable_shadow;
            end
            MODE_PULSE: begin
                pend_shadow |= sel & enable_shadow;
            end
            MODE_WRITE: begin
                if (ev.address == ADDR_VECTOR) begin
                    base_shadow = ev.write_data;
                end else if (ev.address == ADDR_ENABLE) begin
                    enable_shadow = ev.write_data;
                    pend_shadow &= enable_shadow;
                end else if (ev.address == ADDR_ACK) begin
                    pend_shadow &= ~ev.write_data;
                end
            end
            default: ;
        endcase
        // The level-triggered line re-latches on every event while high and enabled.
        pend_shadow |= lvl_shadow & (8'd1 << LEVEL_LINE) & enable_shadow;
        live = pend_shadow & enable_shadow;
        found = 1'b0;
        win = 3'd0;
        for (i = 0; i < NUM_LINES; i++) begin
            if (live[i] && !found) begin
                found = 1'b1;
                win = 3'(i);
            end
        end
        if (ev.mode == MODE_READ) begin
            if (ev.address == ADDR_VECTOR) begin
                rd = base_shadow;
            end else if (ev.address == ADDR_ENABLE) begin
                rd = enable_shadow;
            end else if (ev.address == ADDR_ACK) begin
                rd = 8'd1 << win;
            end
        end
        r.read_data = rd;
        r.irq_pending = found;
        r.irq_line = found ? win : 3'd0;
        r.irq_vector = found ? ((11'(base_shadow) + 11'(win)) << 2) : 11'd0;
        return r;
    endfunction

    function automatic dir_row_t row(mode_t m, int ln, int lvl, int addr, int data,
                                     bit typed, int rd, int pnd, int wl, int vec);
        dir_row_t d;
        d.ev.mode = m;
        d.ev.line = 3'(ln);
        d.ev.level = 1'(lvl);
        d.ev.address = 8'(addr);
        d.ev.write_data = 8'(data);
        d.typed = typed;
        d.want.read_data = 8'(rd);
        d.want.irq_pending = 1'(pnd);
        d.want.irq_line = 3'(wl);
        d.want.irq_vector = 11'(vec);
        return d;
    endfunction

    function automatic logic [7:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return ADDR_ACK;
        if (r < 70) return ADDR_ENABLE;
        if (r < 88) return ADDR_VECTOR;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic item_t random_event();
        item_t ev;
        int    r;
        // Unused fields carry random junk on every event.
        ev.line = 3'($urandom_range(0, 7));
        ev.level = 1'($urandom_range(0, 1));
        ev.address = 8'($urandom_range(0, 255));
        ev.write_data = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 35) begin
            ev.mode = MODE_LEVEL;
            if ($urandom_range(0, 3) == 0) ev.line = 3'(LEVEL_LINE);
        end else if (r < 50) begin
            ev.mode = MODE_PULSE;
        end else if (r < 78) begin
            ev.mode = MODE_WRITE;
            ev.address = pick_address();
            // Keep most lines enabled so that interrupts actually build up.
            if (ev.address == ADDR_ENABLE && $urandom_range(0, 2) != 0)
                ev.write_data |= 8'($urandom_range(0, 255));
        end else begin
            ev.mode = MODE_READ;
            ev.address = pick_address();
        end
        return ev;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < 50)
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic send_event(item_t ev, bit typed, result_t want);
        result_t r;
        if (!calm && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, ev.write_data, ev.address, ev.level, ev.line};
        s_tuser <= ev.mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = apply_irq_event(ev);
        irq_expected.push_back(typed ? want : r);
    endtask

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[22:0];
            if (irq_expected.size() == 0) begin
                report_mismatch("unexpected result beat, m_tdata", m_tdata, 0);
            end else begin
                want = irq_expected.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.irq_pending !== want.irq_pending)
                    report_mismatch("irq_pending", got.irq_pending, want.irq_pending);
                if (got.irq_line !== want.irq_line)
                    report_mismatch("irq_line", got.irq_line, want.irq_line);
                if (got.irq_vector !== want.irq_vector)
                    report_mismatch("irq_vector", got.irq_vector, want.irq_vector);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        result_t none;
        int      k;
        none = '0;
        lvl_shadow = '0;
        pend_shadow = '0;
        enable_shadow = '0;
        base_shadow = '0;

        dir_rows = '{
            row(MODE_READ,  0, 0, ADDR_VECTOR, 8'h00, 1, 8'h00, 0, 0, 0),
            row(MODE_READ,  0, 0, ADDR_ENABLE, 8'h00, 1, 8'h00, 0, 0, 0),
            row(MODE_READ,  0, 0, ADDR_ACK,    8'h00, 1, 8'h01, 0, 0, 0),
            row(MODE_READ,  0, 0, 8'h00,       8'h00, 1, 8'h00, 0, 0, 0),
            row(MODE_PULSE, 5, 1, 8'hFF,       8'hFF, 1, 8'h00, 0, 0, 0),
            row(MODE_WRITE, 0, 0, ADDR_ENABLE, 8'hFF, 1, 8'h00, 0, 0, 0),
            row(MODE_WRITE, 0, 0, ADDR_VECTOR, 8'hFF, 1, 8'h00, 0, 0, 0),
            row(MODE_LEVEL, 7, 1, 8'h00,       8'h00, 1, 8'h00, 1, 7, 1048),
            row(MODE_LEVEL, 0, 1, 8'h00,       8'h00, 1, 8'h00, 1, 0, 1020),
            row(MODE_LEVEL, 0, 0, 8'h00,       8'h00, 0, 0, 0, 0, 0),
            row(MODE_WRITE, 0, 0, ADDR_ACK,    8'h01, 0, 0, 0, 0, 0),
            row(MODE_LEVEL, 3, 1, 8'h00,       8'h00, 0, 0, 0, 0, 0),
            row(MODE_WRITE, 0, 0, ADDR_ACK,    8'h08, 0, 0, 0, 0, 0),
            row(MODE_READ,  0, 0, ADDR_ACK,    8'h00, 0, 0, 0, 0, 0),
            row(MODE_LEVEL, 3, 0, 8'h00,       8'h00, 0, 0, 0, 0, 0),
            row(MODE_WRITE, 0, 0, ADDR_ACK,    8'hFF, 0, 0, 0, 0, 0),
            row(MODE_PULSE, 2, 0, 8'h00,       8'h00, 0, 0, 0, 0, 0),
            row(MODE_WRITE, 0, 0, ADDR_ENABLE, 8'h00, 0, 0, 0, 0, 0),
            row(MODE_WRITE, 7, 1, 8'hFF,       8'hAA, 0, 0, 0, 0, 0),
            row(MODE_READ,  7, 1, 8'hFF,       8'hFF, 0, 0, 0, 0, 0),
            row(MODE_WRITE, 0, 0, ADDR_VECTOR, 8'h00, 0, 0, 0, 0, 0),
            row(MODE_WRITE, 0, 0, ADDR_ENABLE, 8'hFF, 0, 0, 0, 0, 0),
            row(MODE_PULSE, 6, 1, ADDR_VECTOR, 8'hFF, 0, 0, 0, 0, 0),
            row(MODE_READ,  7, 1, ADDR_VECTOR, 8'hFF, 0, 0, 0, 0, 0),
            row(MODE_LEVEL, 7, 1, 8'hFF,       8'hFF, 0, 0, 0, 0, 0)
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);

        for (k = 0; k < RAND_EVENTS; k++) begin
            calm = (k >= 300 && k < 700);
            if (k == 750) begin
                // Let the result side drain completely before going on.
                s_tvalid <= 1'b0;
                while (irq_expected.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end
            send_event(random_event(), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (irq_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && irq_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
